@@ rtl/tbs_pkg.sv @@
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int BYTES_W    = 24;
    localparam int LIM_W      = 20;
    localparam int Q_W        = 28;   // tick quota: limit * 1024 * 250 / 1000 = limit << 8
    localparam int Q_SHIFT    = 8;
    localparam int MAXT_W     = 33;   // quota times at most twenty ticks
    localparam int TOK_W      = 36;
    localparam int DEBT_W     = 35;
    localparam int DIV_W      = 40;
    localparam int SUM_W      = DIV_W + 1;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int NSLOT      = 1 << SLOT_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_A_W    = 2;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_ADD    = 3'd0;
    localparam cmd_t CMD_REMOVE = 3'd1;
    localparam cmd_t CMD_TICK   = 3'd2;
    localparam cmd_t CMD_USE    = 3'd3;
    localparam cmd_t CMD_WAIT   = 3'd4;

    localparam logic [CFG_A_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_IN_LIM  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_OUT_LIM = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_BURST   = 2'd3;

    localparam logic [1:0] BURST_X8  = 2'd1;
    localparam logic [1:0] BURST_X20 = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_ADD_INSERT,
        OP_DIV_QUOTA,
        OP_ADD_APPLY,
        OP_REM_APPLY,
        OP_REM_FINISH,
        OP_USE,
        OP_WAIT,
        OP_EMIT_CMD,
        OP_TICK_INIT,
        OP_TICK_UNLIM,
        OP_TICK_PER,
        OP_TICK_FLOW,
        OP_DIV_LEFT,
        OP_ROUND_PER,
        OP_ROUND_FLOW,
        OP_WAKE_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic             dir;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic             add_ok;
        logic             slot_ok;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       q_zero;
        logic             div_busy;
        logic             quot_zero;
        logic             left_zero;
        logic             nun_zero;
        logic             wake_bit;
        logic             out_free;
    } dp_stat_t;

endpackage

@@ rtl/tbs_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tbs_div
    import tbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    sh;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb begin
        sh        = {rem_reg, quo_reg[DIV_W-1]};
        diff      = sh - {1'b0, dvs_reg};
        ge        = sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/tbs_dp.sv @@
`timescale 1ns / 1ps

// Flow state, configuration, arithmetic and the result register.
module tbs_dp
    import tbs_pkg::*;
#(
    parameter int MAX_FLOWS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_we,
    input  logic [CFG_A_W-1:0]    cfg_addr,
    input  logic [LIM_W-1:0]      cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int NF = (MAX_FLOWS < NSLOT) ? MAX_FLOWS : NSLOT;
    localparam int SW = (NF > 1) ? $clog2(NF) : 1;
    localparam int CW = $clog2(NF + 1);

    // configuration
    logic             en_reg;
    logic [LIM_W-1:0] lim_reg [2];
    logic [1:0]       burst_reg;

    // latched item
    cmd_t               icmd_reg, icmd_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               dir_reg, dir_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;

    // flow state
    logic signed [TOK_W-1:0] tok_reg [NF][2];
    logic signed [TOK_W-1:0] tok_next [NF][2];
    logic [1:0]        wait_reg [NF];
    logic [1:0]        wait_next [NF];
    logic [NF-1:0]     used_reg, used_next;
    logic [SLOT_W-1:0] order_reg [NF];
    logic [SLOT_W-1:0] order_next [NF];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DEBT_W-1:0] debt_reg [2];
    logic [DEBT_W-1:0] debt_next [2];

    // tick working registers
    logic [DIV_W-1:0] per_reg, per_next;
    logic [DIV_W-1:0] left_reg, left_next;
    logic [CW-1:0]    nun_reg, nun_next;
    logic [NF-1:0]    unsat_reg, unsat_next;
    logic [NF-1:0]    wake_reg [2];
    logic [NF-1:0]    wake_next [2];

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_woken_reg, out_woken_next;
    logic                  out_last_reg, out_last_next;

    // divider
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    logic             div_busy;
    logic [DIV_W-1:0] div_quot;

    logic [Q_W-1:0]    q [2];
    logic [MAXT_W-1:0] maxt [2];
    logic [MAXT_W-1:0] qe;
    logic              cd;
    logic [SW-1:0]     kidx;
    logic [SLOT_W-1:0] oslot;
    logic [SW-1:0]     os;
    logic [SW-1:0]     sidx;
    logic              slot_valid;
    logic              slot_ok;
    logic              add_ok;
    logic [SW-1:0]     pos;
    logic              rest;
    logic              out_free;
    logic signed [TOK_W-1:0] tk;
    logic signed [SUM_W-1:0] sum_v;
    logic signed [SUM_W-1:0] mx_v;
    logic signed [SUM_W-1:0] ex_v;
    logic              over;
    logic [Q_W-1:0]    tv;
    logic signed [TOK_W:0] rt;
    logic signed [TOK_W:0] rk;
    logic signed [TOK_W:0] rdiff;
    logic [DEBT_W:0]   dsum;
    logic [CNT_W-1:0]  cnt_div;

    tbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            q[d] = (en_reg && lim_reg[d] != '0) ?
                   {lim_reg[d], {Q_SHIFT{1'b0}}} : '0;
            qe   = MAXT_W'(q[d]);
            case (burst_reg)
                BURST_X8:  maxt[d] = qe << 3;
                BURST_X20: maxt[d] = (qe << 4) + (qe << 2);
                default:   maxt[d] = qe << 2;
            endcase
        end
    end

    always_comb begin
        cd         = cmd.dir;
        kidx       = cmd.idx[SW-1:0];
        oslot      = order_reg[kidx];
        os         = oslot[SW-1:0];
        sidx       = slot_reg[SW-1:0];
        slot_valid = int'(slot_reg) < NF;
        slot_ok    = slot_valid && used_reg[sidx];
        add_ok     = slot_valid && !used_reg[sidx] && (int'(cnt_reg) < NF);
        out_free   = !out_valid_reg || m_tready;
        cnt_div    = (cnt_reg == '0) ? CNT_W'(1) : CNT_W'(cnt_reg);

        pos = '0;
        for (int k = NF - 1; k >= 0; k--) begin
            if (k < int'(cnt_reg) && order_reg[k] == slot_reg) begin
                pos = SW'(k);
            end
        end

        rest = 1'b0;
        for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < NF; k++) begin
                if (wake_reg[d][k] && !((1'(d) == cd) && (k == int'(kidx)))) begin
                    rest = 1'b1;
                end
            end
        end

        // one bucket step for the flow at position kidx
        tk    = tok_reg[os][cd];
        sum_v = $signed({{(SUM_W-TOK_W){tk[TOK_W-1]}}, tk}) + $signed({1'b0, per_reg});
        mx_v  = $signed({{(SUM_W-MAXT_W){1'b0}}, maxt[cd]});
        ex_v  = sum_v - mx_v;
        over  = sum_v > mx_v;

        tv    = div_quot[Q_W-1:0];
        rt    = $signed({{(TOK_W+1-Q_W){1'b0}}, div_quot[Q_W-1:0]});
        rk    = $signed({tok_reg[sidx][cd][TOK_W-1], tok_reg[sidx][cd]});
        rdiff = rt - rk;
        dsum  = {1'b0, debt_reg[cd]} + rdiff[DEBT_W:0];

        icmd_next  = icmd_reg;
        slot_next  = slot_reg;
        dir_next   = dir_reg;
        bytes_next = bytes_reg;
        tok_next   = tok_reg;
        wait_next  = wait_reg;
        used_next  = used_reg;
        order_next = order_reg;
        cnt_next   = cnt_reg;
        debt_next  = debt_reg;
        per_next   = per_reg;
        left_next  = left_reg;
        nun_next   = nun_reg;
        unsat_next = unsat_reg;
        wake_next  = wake_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_woken_next = out_woken_reg;
        out_last_next  = out_last_reg;

        div_start    = 1'b0;
        div_dividend = DIV_W'(q[cd]);
        div_divisor  = cnt_div;

        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_LATCH: begin
                icmd_next  = s_tuser;
                slot_next  = s_tdata[SLOT_W-1:0];
                dir_next   = s_tdata[SLOT_W];
                bytes_next = s_tdata[SLOT_W+BYTES_W:SLOT_W+1];
            end
            OP_ADD_INSERT: begin
                order_next[cnt_reg[SW-1:0]] = slot_reg;
                cnt_next        = cnt_reg + CW'(1);
                used_next[sidx] = 1'b1;
                wait_next[sidx] = 2'b00;
            end
            OP_DIV_QUOTA: begin
                div_start = 1'b1;
            end
            OP_ADD_APPLY: begin
                if (q[cd] != '0) begin
                    if (debt_reg[cd] != '0) begin
                        if (DEBT_W'(tv) >= debt_reg[cd]) begin
                            tv            = tv - Q_W'(debt_reg[cd]);
                            debt_next[cd] = '0;
                        end else begin
                            debt_next[cd] = debt_reg[cd] - DEBT_W'(tv);
                            tv            = '0;
                        end
                    end
                    tok_next[sidx][cd] = $signed(TOK_W'(tv));
                end else begin
                    tok_next[sidx][cd] = '1;
                end
            end
            OP_REM_APPLY: begin
                if (rk < rt) begin
                    debt_next[cd] = dsum[DEBT_W] ? '1 : dsum[DEBT_W-1:0];
                end
            end
            OP_REM_FINISH: begin
                for (int k = 0; k < NF - 1; k++) begin
                    if (k >= int'(pos)) begin
                        order_next[k] = order_reg[k+1];
                    end
                end
                cnt_next           = cnt_reg - CW'(1);
                used_next[sidx]    = 1'b0;
                tok_next[sidx][0]  = '1;
                tok_next[sidx][1]  = '1;
                wait_next[sidx]    = 2'b00;
            end
            OP_USE: begin
                if (slot_ok) begin
                    if ($signed({{(TOK_W-BYTES_W){1'b0}}, bytes_reg}) >
                        tok_reg[sidx][dir_reg]) begin
                        tok_next[sidx][dir_reg] = '0;
                    end else begin
                        tok_next[sidx][dir_reg] = tok_reg[sidx][dir_reg] -
                            $signed({{(TOK_W-BYTES_W){1'b0}}, bytes_reg});
                    end
                end
            end
            OP_WAIT: begin
                if (slot_ok) begin
                    wait_next[sidx][dir_reg] = 1'b1;
                end
            end
            OP_EMIT_CMD: begin
                out_valid_next = 1'b1;
                out_data_next  = {{(OUT_DATA_W-SLOT_W-TOK_W-2){1'b0}},
                                  slot_valid && wait_reg[sidx][dir_reg],
                                  slot_valid ? tok_reg[sidx][dir_reg] : {TOK_W{1'b1}},
                                  dir_reg, slot_reg};
                out_woken_next = 1'b0;
                out_last_next  = 1'b1;
            end
            OP_TICK_INIT: begin
                debt_next[cd] = '0;
                left_next     = '0;
                nun_next      = '0;
                wake_next[cd] = '0;
                div_start     = 1'b1;
            end
            OP_TICK_UNLIM: begin
                tok_next[os][cd] = '1;
                if (wait_reg[os][cd]) begin
                    wake_next[cd][kidx] = 1'b1;
                end
            end
            OP_TICK_PER: begin
                per_next = (div_quot == '0) ? DIV_W'(1) : div_quot;
            end
            OP_TICK_FLOW: begin
                if (tk < 0) begin
                    tok_next[os][cd] = $signed(TOK_W'(per_reg));
                    unsat_next[kidx] = 1'b1;
                    nun_next         = nun_reg + CW'(1);
                end else begin
                    if (over) begin
                        left_next        = left_reg + ex_v[DIV_W-1:0];
                        tok_next[os][cd] = $signed(TOK_W'(maxt[cd]));
                        unsat_next[kidx] = 1'b0;
                    end else begin
                        tok_next[os][cd] = sum_v[TOK_W-1:0];
                        unsat_next[kidx] = 1'b1;
                        nun_next         = nun_reg + CW'(1);
                    end
                    if (wait_reg[os][cd]) begin
                        wake_next[cd][kidx] = 1'b1;
                    end
                end
            end
            OP_DIV_LEFT: begin
                div_start    = 1'b1;
                div_dividend = left_reg;
                div_divisor  = CNT_W'(nun_reg);
            end
            OP_ROUND_PER: begin
                per_next  = div_quot;
                left_next = '0;
            end
            OP_ROUND_FLOW: begin
                if (unsat_reg[kidx]) begin
                    if (over) begin
                        left_next        = left_reg + ex_v[DIV_W-1:0];
                        tok_next[os][cd] = $signed(TOK_W'(maxt[cd]));
                        unsat_next[kidx] = 1'b0;
                        nun_next         = nun_reg - CW'(1);
                    end else begin
                        tok_next[os][cd] = sum_v[TOK_W-1:0];
                    end
                end
            end
            OP_WAKE_EMIT: begin
                wait_next[os][cd]   = 1'b0;
                wake_next[cd][kidx] = 1'b0;
                out_valid_next      = 1'b1;
                out_data_next       = {{(OUT_DATA_W-SLOT_W-TOK_W-2){1'b0}}, 1'b0,
                                       tok_reg[os][cd], cd, oslot};
                out_woken_next      = 1'b1;
                out_last_next       = !rest;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg        <= 1'b0;
            lim_reg[0]    <= '0;
            lim_reg[1]    <= '0;
            burst_reg     <= '0;
            used_reg      <= '0;
            cnt_reg       <= '0;
            debt_reg[0]   <= '0;
            debt_reg[1]   <= '0;
            wake_reg[0]   <= '0;
            wake_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NF; s++) begin
                tok_reg[s][0] <= '1;
                tok_reg[s][1] <= '1;
                wait_reg[s]   <= 2'b00;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_ENABLE:  en_reg     <= cfg_wdata[0];
                    CFG_IN_LIM:  lim_reg[0] <= cfg_wdata;
                    CFG_OUT_LIM: lim_reg[1] <= cfg_wdata;
                    CFG_BURST:   burst_reg  <= cfg_wdata[1:0];
                endcase
            end
            used_reg      <= used_next;
            cnt_reg       <= cnt_next;
            debt_reg      <= debt_next;
            wake_reg      <= wake_next;
            out_valid_reg <= out_valid_next;
            tok_reg       <= tok_next;
            wait_reg      <= wait_next;
        end
    end

    always_ff @(posedge aclk) begin
        icmd_reg      <= icmd_next;
        slot_reg      <= slot_next;
        dir_reg       <= dir_next;
        bytes_reg     <= bytes_next;
        order_reg     <= order_next;
        per_reg       <= per_next;
        left_reg      <= left_next;
        nun_reg       <= nun_next;
        unsat_reg     <= unsat_next;
        out_data_reg  <= out_data_next;
        out_woken_reg <= out_woken_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        stat.cmd       = icmd_reg;
        stat.add_ok    = add_ok;
        stat.slot_ok   = slot_ok;
        stat.cnt       = CNT_W'(cnt_reg);
        stat.q_zero[0] = q[0] == '0;
        stat.q_zero[1] = q[1] == '0;
        stat.div_busy  = div_busy;
        stat.quot_zero = div_quot == '0;
        stat.left_zero = left_reg == '0;
        stat.nun_zero  = nun_reg == '0;
        stat.wake_bit  = wake_reg[cd][kidx];
        stat.out_free  = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_woken_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/tbs_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: walks commands, directions and flow positions.
module tbs_ctrl
    import tbs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_DIV,
        ST_ADD_WAIT,
        ST_ADD_APPLY,
        ST_REM_DIV,
        ST_REM_WAIT,
        ST_REM_APPLY,
        ST_REM_FINISH,
        ST_EMIT,
        ST_T_INIT,
        ST_T_UNLIM,
        ST_T_DIVW,
        ST_T_FLOW,
        ST_T_ROUND,
        ST_T_RDIVW,
        ST_T_RFLOW,
        ST_T_NEXTD,
        ST_W_SCAN
    } state_t;

    state_t           state_reg, state_next;
    logic             dir_reg, dir_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             k_last;
    logic             adv;

    assign k_last = ({1'b0, k_reg} + CNT_W'(1)) == stat.cnt;

    always_comb begin
        state_next = state_reg;
        dir_next   = dir_reg;
        k_next     = k_reg;
        adv        = 1'b0;
        cmd.op     = OP_NONE;
        cmd.dir    = dir_reg;
        cmd.idx    = k_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                dir_next = 1'b0;
                unique case (stat.cmd)
                    CMD_ADD: begin
                        if (stat.add_ok) begin
                            cmd.op     = OP_ADD_INSERT;
                            state_next = ST_ADD_DIV;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                    CMD_REMOVE: begin
                        state_next = stat.slot_ok ? ST_REM_DIV : ST_EMIT;
                    end
                    CMD_TICK: begin
                        state_next = ST_T_INIT;
                    end
                    CMD_USE: begin
                        cmd.op     = OP_USE;
                        state_next = ST_EMIT;
                    end
                    CMD_WAIT: begin
                        cmd.op     = OP_WAIT;
                        state_next = ST_EMIT;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADD_DIV: begin
                cmd.op     = OP_DIV_QUOTA;
                state_next = ST_ADD_WAIT;
            end
            ST_ADD_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ST_ADD_APPLY;
                end
            end
            ST_ADD_APPLY: begin
                cmd.op = OP_ADD_APPLY;
                if (dir_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    dir_next   = 1'b1;
                    state_next = ST_ADD_DIV;
                end
            end
            ST_REM_DIV: begin
                cmd.op     = OP_DIV_QUOTA;
                state_next = ST_REM_WAIT;
            end
            ST_REM_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ST_REM_APPLY;
                end
            end
            ST_REM_APPLY: begin
                cmd.op = OP_REM_APPLY;
                if (dir_reg) begin
                    state_next = ST_REM_FINISH;
                end else begin
                    dir_next   = 1'b1;
                    state_next = ST_REM_DIV;
                end
            end
            ST_REM_FINISH: begin
                cmd.op     = OP_REM_FINISH;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_CMD;
                    state_next = ST_IDLE;
                end
            end
            ST_T_INIT: begin
                cmd.op = OP_TICK_INIT;
                k_next = '0;
                if (stat.cnt == '0) begin
                    state_next = ST_T_NEXTD;
                end else if (stat.q_zero[dir_reg]) begin
                    state_next = ST_T_UNLIM;
                end else begin
                    state_next = ST_T_DIVW;
                end
            end
            ST_T_UNLIM: begin
                cmd.op = OP_TICK_UNLIM;
                if (k_last) begin
                    state_next = ST_T_NEXTD;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_T_DIVW: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_TICK_PER;
                    k_next     = '0;
                    state_next = ST_T_FLOW;
                end
            end
            ST_T_FLOW: begin
                cmd.op = OP_TICK_FLOW;
                if (k_last) begin
                    state_next = ST_T_ROUND;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_T_ROUND: begin
                if (stat.left_zero || stat.nun_zero) begin
                    state_next = ST_T_NEXTD;
                end else begin
                    cmd.op     = OP_DIV_LEFT;
                    state_next = ST_T_RDIVW;
                end
            end
            ST_T_RDIVW: begin
                if (!stat.div_busy) begin
                    if (stat.quot_zero) begin
                        state_next = ST_T_NEXTD;
                    end else begin
                        cmd.op     = OP_ROUND_PER;
                        k_next     = '0;
                        state_next = ST_T_RFLOW;
                    end
                end
            end
            ST_T_RFLOW: begin
                cmd.op = OP_ROUND_FLOW;
                if (k_last) begin
                    state_next = ST_T_ROUND;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_T_NEXTD: begin
                k_next = '0;
                if (!dir_reg) begin
                    dir_next   = 1'b1;
                    state_next = ST_T_INIT;
                end else begin
                    dir_next   = 1'b0;
                    state_next = ST_W_SCAN;
                end
            end
            ST_W_SCAN: begin
                if (stat.cnt == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    if (stat.wake_bit) begin
                        if (stat.out_free) begin
                            cmd.op = OP_WAKE_EMIT;
                            adv    = 1'b1;
                        end
                    end else begin
                        adv = 1'b1;
                    end
                    if (adv) begin
                        if (k_last) begin
                            k_next = '0;
                            if (dir_reg) begin
                                state_next = ST_IDLE;
                            end else begin
                                dir_next = 1'b1;
                            end
                        end else begin
                            k_next = k_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dir_reg   <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            k_reg     <= k_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule

@@ rtl/multi_flow_token_bucket_shaper_unit.sv @@
`timescale 1ns / 1ps

// Token-bucket shaper shared by up to MAX_FLOWS flows (at most 16), inbound and outbound.
// Input channel (s_): one command item per handshake; tuser carries the command
// (add, remove, tick, use bytes, wait), tdata the flow slot, direction and byte count.
// Result channel (m_): flow slot, direction, tokens available (-1 means unlimited) and
// the waiting flag in tdata; tuser marks a tick wakeup, tlast the last result of an item.
// The block takes one item at a time; s_tready is high only while it is idle.
// Use and wait update the flow on decode, then emit their result once the output
// register is free. Add and remove divide the per-tick quota by the flow count for each
// direction in a bit-serial divider. A tick walks all flows of each limited direction
// once (one flow per cycle), then runs redistribution rounds of one division plus one
// pass over the flows each; a scan over all flows and directions then sends wakeups.
// Results sit in an output register: while the receiver stalls, the sequencer holds at
// the next result and the finished one stays on m_tdata. Reset clears all flows, debts
// and waiting flags, makes every flow unlimited and zeroes the configuration.
// The user must write configuration through cfg_we/cfg_addr/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module multi_flow_token_bucket_shaper_unit
    import tbs_pkg::*;
#(
    parameter int MAX_FLOWS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: 0 enable, 1 inbound KiB/s, 2 outbound KiB/s, 3 burst tolerance
    input  logic                  cfg_we,
    input  logic [CFG_A_W-1:0]    cfg_addr,
    input  logic [LIM_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: flow_slot [3:0], direction [4], used_bytes [28:5], zeros [31:29]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: command [2:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: out_slot [3:0], out_direction [4], bytes_available [40:5],
    // is_waiting [41], zeros [47:42]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tuser: woken
    output logic                  m_tuser,
    output logic                  m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The sequencer issues one datapath operation per cycle, none while it waits.
    tbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath keeps all flow state, the configuration and the result register.
    tbs_dp #(
        .MAX_FLOWS (MAX_FLOWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
